// ----- design/fsc_pkg.sv -----
// ----------------------------------------------------------------------------
// fsc_pkg: shared types and constants of the frequency source checker
// Field widths, verdict codes, sequencer states and the shift-add schedule
// used to scale a frequency difference by one million.
// ----------------------------------------------------------------------------
`default_nettype none

package fsc_pkg;

  // Field widths
  localparam int HZ_W      = 40;
  localparam int BRACKET_W = 20;
  localparam int PPM_W     = 32;
  localparam int IDX_W     = 2;
  localparam int CIDX_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 128;
  localparam int OUT_USER_W = 3;

  // Datapath widths: the scaled difference is below 2^60, the shared adder
  // has one spare bit for the divide step
  localparam int ACC_W  = 60;
  localparam int AU_W   = 61;
  localparam int STEP_W = 5;

  // Bound terms in ppm
  localparam int PHASE_SLEW_INT = (500000000 / 1000) >> 2;
  localparam logic [BRACKET_W-1:0] BASE_BOUND_PPM = 20'd1000;
  localparam logic [BRACKET_W-1:0] HOST_SLEW_PPM  = BRACKET_W'(PHASE_SLEW_INT);
  localparam logic [PPM_W-1:0]     AGREE_PPM      = 32'd10;

  // 1000000 = sum of 2^k over these bit positions
  localparam int MUL_STEPS = 7;
  localparam logic [STEP_W-1:0] PPM_SHIFT [0:MUL_STEPS-1] =
    '{5'd6, 5'd9, 5'd14, 5'd16, 5'd17, 5'd18, 5'd19};
  localparam int DIV_STEPS = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MEASURED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRACKET    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HYPERVISOR = 2'd2;

  typedef enum logic [2:0] {
    V_ABSENT      = 3'd0,
    V_UNCHECKED   = 3'd1,
    V_CONTRADICTS = 3'd2,
    V_ADOPTED     = 3'd3,
    V_AGREES      = 3'd4,
    V_NOT_USED    = 3'd5
  } verdict_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_DIFF,
    S_DIFFN,
    S_MUL,
    S_SAT,
    S_DIV,
    S_EVAL,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- design/frequency_source_checker_core.sv -----
// ----------------------------------------------------------------------------
// frequency_source_checker_core: stated clock rate check against a measurement
// Grades each source rate by its ppm distance from the measured rate and
// tracks the first source adopted in the current choice.
// ----------------------------------------------------------------------------
`default_nettype none

// One source is checked per transaction and the block takes no new item until
// its result is loaded into the output register. An absent or unchecked source
// goes from the start step straight to the output load. A checked source runs
// start, one difference step or two when the source lies below the reference,
// the shift-add steps, a saturation check, 32 divide steps, the evaluation and
// the output load; a saturated distance skips the 32 divide steps. A source that
// must also be compared with the adopted rate runs the distance a second time,
// from the difference step on. The difference, shift-add, saturation and divide
// steps go through a single 61-bit adder/subtractor. The load waits while a
// previous result is still held in the output register; a finished result may
// wait there while the next source is accepted. Configuration writes are always
// accepted and must only be made while no source is in flight.
module frequency_source_checker_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Configuration write channel
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [fsc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [fsc_pkg::HZ_W-1:0]           cfg_data,
  // Source input stream
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [fsc_pkg::IN_DATA_W-1:0]      in_tdata,   // [39:0] source_hz
  input  wire logic [fsc_pkg::IN_USER_W-1:0]      in_tuser,   // [1:0] source_index, [2] first_source
  // Result stream
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [fsc_pkg::OUT_DATA_W-1:0]          out_tdata,  // [31:0] ppm_from_measured,
                                                              // [63:32] ppm_from_adopted,
                                                              // [83:64] agree_bound,
                                                              // [123:84] chosen_hz,
                                                              // [126:124] chosen_index, [127] zero
  output logic [fsc_pkg::OUT_USER_W-1:0]          out_tuser   // [2:0] verdict
);

  // Configuration registers
  logic [fsc_pkg::HZ_W-1:0]       measured_r;
  logic [fsc_pkg::BRACKET_W-1:0]  bracket_r;
  logic                           hyper_r;

  // Sequencer and item registers
  fsc_pkg::state_t                state_r, state_nxt;
  logic                           pass_r, pass_nxt;
  logic [fsc_pkg::HZ_W-1:0]       hz_r, hz_nxt;
  logic [fsc_pkg::IDX_W-1:0]      idx_r, idx_nxt;
  logic [fsc_pkg::BRACKET_W-1:0]  bound_r, bound_nxt;
  logic [fsc_pkg::HZ_W-1:0]       ref_r, ref_nxt;
  logic [fsc_pkg::HZ_W-1:0]       dif_r, dif_nxt;
  logic [fsc_pkg::ACC_W-1:0]      acc_r, acc_nxt;
  logic [fsc_pkg::HZ_W-1:0]       rem_r, rem_nxt;
  logic [fsc_pkg::STEP_W-1:0]     step_r, step_nxt;
  fsc_pkg::verdict_t              verdict_r, verdict_nxt;
  logic [fsc_pkg::PPM_W-1:0]      meas_ppm_r, meas_ppm_nxt;
  logic [fsc_pkg::PPM_W-1:0]      adopt_ppm_r, adopt_ppm_nxt;

  // Adoption state
  logic                           have_r, have_nxt;
  logic [fsc_pkg::HZ_W-1:0]       rate_r, rate_nxt;
  logic [fsc_pkg::IDX_W-1:0]      pos_r, pos_nxt;

  // Output register
  logic                           out_valid_r, out_valid_nxt;
  logic [fsc_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [fsc_pkg::OUT_USER_W-1:0] out_user_r, out_user_nxt;

  // Shared adder/subtractor
  logic [fsc_pkg::AU_W-1:0]       au_a, au_b;
  logic                           au_sub;
  logic [fsc_pkg::AU_W:0]         au_sum;
  logic [fsc_pkg::AU_W-1:0]       au_res;
  logic                           au_ge;

  logic                           in_acc;
  logic                           out_free;
  logic [fsc_pkg::BRACKET_W-1:0]  bound_calc;
  logic [fsc_pkg::PPM_W-1:0]      quot;
  logic [fsc_pkg::CIDX_W-1:0]     cidx_calc;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == fsc_pkg::S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign quot       = acc_r[fsc_pkg::PPM_W-1:0];

  // Bound for this choice from the configuration
  assign bound_calc = (bracket_r >> 1) + fsc_pkg::BASE_BOUND_PPM
                      + (hyper_r ? fsc_pkg::HOST_SLEW_PPM : '0);

  // Adopted source after this item, -1 when none
  assign cidx_calc = have_r ? {1'b0, pos_r} : '1;

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      measured_r <= '0;
      bracket_r  <= '0;
      hyper_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == fsc_pkg::CFG_MEASURED) begin
        measured_r <= cfg_data;
      end
      if (cfg_index == fsc_pkg::CFG_BRACKET) begin
        bracket_r <= cfg_data[fsc_pkg::BRACKET_W-1:0];
      end
      if (cfg_index == fsc_pkg::CFG_HYPERVISOR) begin
        hyper_r <= cfg_data[0];
      end
    end
  end

  // Operand selection for the shared unit
  always_comb begin
    au_a   = '0;
    au_b   = '0;
    au_sub = 1'b1;
    unique case (state_r)
      fsc_pkg::S_DIFF: begin
        au_a = fsc_pkg::AU_W'(hz_r);
        au_b = fsc_pkg::AU_W'(ref_r);
      end
      fsc_pkg::S_DIFFN: begin
        au_a = fsc_pkg::AU_W'(ref_r);
        au_b = fsc_pkg::AU_W'(hz_r);
      end
      fsc_pkg::S_MUL: begin
        au_a   = fsc_pkg::AU_W'(acc_r);
        au_b   = fsc_pkg::AU_W'(dif_r) << fsc_pkg::PPM_SHIFT[step_r[2:0]];
        au_sub = 1'b0;
      end
      fsc_pkg::S_SAT: begin
        // Quotient saturates when the upper part reaches the reference
        au_a = fsc_pkg::AU_W'(acc_r[fsc_pkg::ACC_W-1:fsc_pkg::PPM_W]);
        au_b = fsc_pkg::AU_W'(ref_r);
      end
      fsc_pkg::S_DIV: begin
        au_a = fsc_pkg::AU_W'({rem_r, acc_r[fsc_pkg::PPM_W-1]});
        au_b = fsc_pkg::AU_W'(ref_r);
      end
      default: begin
        au_a   = '0;
        au_b   = '0;
        au_sub = 1'b1;
      end
    endcase
  end

  assign au_sum = {1'b0, au_a} + {1'b0, (au_sub ? ~au_b : au_b)}
                  + (fsc_pkg::AU_W+1)'(au_sub);
  assign au_res = au_sum[fsc_pkg::AU_W-1:0];
  assign au_ge  = au_sum[fsc_pkg::AU_W];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fsc_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = fsc_pkg::S_START;
        end
      end
      fsc_pkg::S_START: begin
        if (hz_r == '0 || measured_r == '0) begin
          state_nxt = fsc_pkg::S_DONE;
        end else begin
          state_nxt = fsc_pkg::S_DIFF;
        end
      end
      fsc_pkg::S_DIFF: begin
        state_nxt = au_ge ? fsc_pkg::S_MUL : fsc_pkg::S_DIFFN;
      end
      fsc_pkg::S_DIFFN: begin
        state_nxt = fsc_pkg::S_MUL;
      end
      fsc_pkg::S_MUL: begin
        if (step_r == fsc_pkg::STEP_W'(fsc_pkg::MUL_STEPS - 1)) begin
          state_nxt = fsc_pkg::S_SAT;
        end
      end
      fsc_pkg::S_SAT: begin
        state_nxt = au_ge ? fsc_pkg::S_EVAL : fsc_pkg::S_DIV;
      end
      fsc_pkg::S_DIV: begin
        if (step_r == fsc_pkg::STEP_W'(fsc_pkg::DIV_STEPS - 1)) begin
          state_nxt = fsc_pkg::S_EVAL;
        end
      end
      fsc_pkg::S_EVAL: begin
        if (!pass_r && quot <= fsc_pkg::PPM_W'(bound_r) && have_r) begin
          state_nxt = fsc_pkg::S_DIFF;
        end else begin
          state_nxt = fsc_pkg::S_DONE;
        end
      end
      fsc_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = fsc_pkg::S_IDLE;
        end
      end
      default: state_nxt = fsc_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    pass_nxt      = pass_r;
    hz_nxt        = hz_r;
    idx_nxt       = idx_r;
    bound_nxt     = bound_r;
    ref_nxt       = ref_r;
    dif_nxt       = dif_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    verdict_nxt   = verdict_r;
    meas_ppm_nxt  = meas_ppm_r;
    adopt_ppm_nxt = adopt_ppm_r;
    have_nxt      = have_r;
    rate_nxt      = rate_r;
    pos_nxt       = pos_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      fsc_pkg::S_IDLE: begin
        if (in_acc) begin
          hz_nxt        = in_tdata[fsc_pkg::HZ_W-1:0];
          idx_nxt       = in_tuser[fsc_pkg::IDX_W-1:0];
          bound_nxt     = bound_calc;
          ref_nxt       = measured_r;
          pass_nxt      = 1'b0;
          meas_ppm_nxt  = '0;
          adopt_ppm_nxt = '0;
          // First source of a choice drops the earlier adoption
          if (in_tuser[fsc_pkg::IDX_W]) begin
            have_nxt = 1'b0;
            rate_nxt = '0;
            pos_nxt  = '0;
          end
        end
      end
      fsc_pkg::S_START: begin
        if (hz_r == '0) begin
          verdict_nxt = fsc_pkg::V_ABSENT;
        end else if (measured_r == '0) begin
          verdict_nxt = fsc_pkg::V_UNCHECKED;
        end
      end
      fsc_pkg::S_DIFF: begin
        dif_nxt  = au_res[fsc_pkg::HZ_W-1:0];
        acc_nxt  = '0;
        step_nxt = '0;
      end
      fsc_pkg::S_DIFFN: begin
        dif_nxt  = au_res[fsc_pkg::HZ_W-1:0];
        acc_nxt  = '0;
        step_nxt = '0;
      end
      fsc_pkg::S_MUL: begin
        acc_nxt  = au_res[fsc_pkg::ACC_W-1:0];
        step_nxt = step_r + fsc_pkg::STEP_W'(1);
      end
      fsc_pkg::S_SAT: begin
        if (au_ge) begin
          acc_nxt[fsc_pkg::PPM_W-1:0] = '1;
        end else begin
          rem_nxt  = fsc_pkg::HZ_W'(acc_r[fsc_pkg::ACC_W-1:fsc_pkg::PPM_W]);
          step_nxt = '0;
        end
      end
      fsc_pkg::S_DIV: begin
        // Restoring divide step, quotient bits shift in from the bottom
        if (au_ge) begin
          rem_nxt = au_res[fsc_pkg::HZ_W-1:0];
        end else begin
          rem_nxt = {rem_r[fsc_pkg::HZ_W-2:0], acc_r[fsc_pkg::PPM_W-1]};
        end
        acc_nxt[fsc_pkg::PPM_W-1:0] = {acc_r[fsc_pkg::PPM_W-2:0], au_ge};
        step_nxt = step_r + fsc_pkg::STEP_W'(1);
      end
      fsc_pkg::S_EVAL: begin
        if (!pass_r) begin
          meas_ppm_nxt = quot;
          if (quot > fsc_pkg::PPM_W'(bound_r)) begin
            verdict_nxt = fsc_pkg::V_CONTRADICTS;
          end else if (!have_r) begin
            have_nxt    = 1'b1;
            rate_nxt    = hz_r;
            pos_nxt     = idx_r;
            verdict_nxt = fsc_pkg::V_ADOPTED;
          end else begin
            pass_nxt = 1'b1;
            ref_nxt  = rate_r;
          end
        end else begin
          adopt_ppm_nxt = quot;
          verdict_nxt   = (quot <= fsc_pkg::AGREE_PPM) ? fsc_pkg::V_AGREES
                                                       : fsc_pkg::V_NOT_USED;
        end
      end
      fsc_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = verdict_r;
          out_data_nxt  = {1'b0, cidx_calc, (have_r ? rate_r : '0), bound_r,
                           adopt_ppm_r, meas_ppm_r};
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && !out_tready;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fsc_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      have_r      <= 1'b0;
      rate_r      <= '0;
      pos_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      have_r      <= have_nxt;
      rate_r      <= rate_nxt;
      pos_r       <= pos_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pass_r      <= pass_nxt;
    hz_r        <= hz_nxt;
    idx_r       <= idx_nxt;
    bound_r     <= bound_nxt;
    ref_r       <= ref_nxt;
    dif_r       <= dif_nxt;
    acc_r       <= acc_nxt;
    rem_r       <= rem_nxt;
    step_r      <= step_nxt;
    verdict_r   <= verdict_nxt;
    meas_ppm_r  <= meas_ppm_nxt;
    adopt_ppm_r <= adopt_ppm_nxt;
    out_data_r  <= out_data_nxt;
    out_user_r  <= out_user_nxt;
  end

  // Assertions

  // One source at a time: an accepted transaction closes the input
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a source was in flight");

  // Divider remainder stays below the reference
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == fsc_pkg::S_DIV |-> rem_r < ref_r)
    else $error("divide remainder out of range");

  // An adopted source always has a nonzero rate
  a_adopt_rate: assert property (@(posedge clk) disable iff (!rst_n)
    have_r |-> rate_r != '0)
    else $error("adoption recorded with zero rate");

  // Absent and unchecked results carry no distances
  a_no_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_user_r == fsc_pkg::V_ABSENT || out_user_r == fsc_pkg::V_UNCHECKED)
    |-> out_data_r[2*fsc_pkg::PPM_W-1:0] == '0)
    else $error("distance reported for unchecked source");

  // An adopted verdict always names a source
  a_adopt_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_user_r == fsc_pkg::V_ADOPTED |-> out_data_r[126] == 1'b0)
    else $error("adopted verdict without chosen index");

endmodule

`default_nettype wire

// ----- tb/sv/frequency_source_checker_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frequency_source_checker_core_tb: self-checking bench for the source checker
// Drives source transactions through the input stream and grades each one in a
// local copy of the checker's state. Every result transaction is compared
// field by field with the oldest pending grade. A directed table covers the
// verdicts and the distance, bound and saturation corners. Random phases
// follow, each under fresh register settings, with bursty input and a stalling
// receiver.
// ----------------------------------------------------------------------------
module frequency_source_checker_core_tb;

  localparam int CLK_PERIOD = 12;
  localparam int RAND_PHASES = 12;
  localparam int ITEMS_PER_PHASE = 34;
  localparam int DRAIN_CYCLES = 8;
  localparam int TAIL_CYCLES = 200;
  // Budget for all directed and random sources, plus receiver stalls, sender
  // gaps and the idle waits between phases; taken several times over
  localparam int LIMIT_CYCLES = 600000;

  localparam logic [31:0] AGREE_LIMIT = 32'd10;
  localparam logic [31:0] BASE_SLACK = 32'd1000;
  localparam logic [31:0] HOST_SLEW = 32'd125000;
  localparam logic [63:0] MAX_RATE = 64'hFF_FFFF_FFFF;
  localparam logic [2:0] NO_PICK = 3'b111;
  // Index with no register behind it
  localparam logic [fsc_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    fsc_pkg::verdict_t verdict;
    logic [fsc_pkg::PPM_W-1:0] from_meas;
    logic [fsc_pkg::PPM_W-1:0] from_held;
    logic [fsc_pkg::BRACKET_W-1:0] bound;
    logic [fsc_pkg::HZ_W-1:0] chosen_hz;
    logic [fsc_pkg::CIDX_W-1:0] chosen_idx;
  } grade_t;

  typedef enum {ROW_WRITE, ROW_SOURCE} row_kind_t;

  typedef struct {
    row_kind_t kind;
    logic [fsc_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [fsc_pkg::HZ_W-1:0] reg_val;
    logic [fsc_pkg::IDX_W-1:0] src_idx;
    logic [fsc_pkg::HZ_W-1:0] src_hz;
    logic first_flag;
    bit typed;
    grade_t want;
  } row_t;

  // DUT ports
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [fsc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [fsc_pkg::HZ_W-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [fsc_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic [fsc_pkg::IN_USER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [fsc_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [fsc_pkg::OUT_USER_W-1:0] out_tuser;

  // Register model
  logic [fsc_pkg::HZ_W-1:0] meas_rate = '0;
  logic [fsc_pkg::BRACKET_W-1:0] bracket_width = '0;
  logic host_slew_on = 1'b0;

  // Adoption state of the current choice
  logic held_valid = 1'b0;
  logic [fsc_pkg::HZ_W-1:0] held_rate = '0;
  logic [fsc_pkg::IDX_W-1:0] held_pos = '0;

  grade_t due_grades[$];
  row_t stim_table[$];

  int errors = 0;
  int sources_sent = 0;
  int directed_sent = 0;
  int grades_checked = 0;
  int settings_used = 1;
  int verdict_seen[0:5] = '{default: 0};
  int cycle_count = 0;

  logic [31:0] stall_pat = '1;
  logic [4:0] stall_pos = '0;

  frequency_source_checker_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Truncated ppm distance of x from base, saturated to 32 bits
  function automatic logic [fsc_pkg::PPM_W-1:0] rate_distance(logic [fsc_pkg::HZ_W-1:0] x,
                                                              logic [fsc_pkg::HZ_W-1:0] base);
    logic [63:0] d;
    logic [63:0] q;
    if (base == '0) return '0;
    d = (x > base) ? 64'(x - base) : 64'(base - x);
    q = d * 64'd1000000 / 64'(base);
    return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  function automatic logic [fsc_pkg::BRACKET_W-1:0] bound_now();
    logic [31:0] b;
    b = 32'(bracket_width >> 1) + BASE_SLACK + (host_slew_on ? HOST_SLEW : 32'd0);
    return b[fsc_pkg::BRACKET_W-1:0];
  endfunction

  // Grade one source and advance the adoption state
  function automatic grade_t grade_source(logic [fsc_pkg::IDX_W-1:0] idx,
                                          logic [fsc_pkg::HZ_W-1:0] hz, logic first);
    grade_t g;
    g.bound = bound_now();
    g.from_meas = '0;
    g.from_held = '0;
    if (first) begin
      held_valid = 1'b0;
      held_rate = '0;
      held_pos = '0;
    end
    if (hz == '0) begin
      g.verdict = fsc_pkg::V_ABSENT;
    end else if (meas_rate == '0) begin
      g.verdict = fsc_pkg::V_UNCHECKED;
    end else begin
      g.from_meas = rate_distance(hz, meas_rate);
      if (g.from_meas > 32'(g.bound)) begin
        g.verdict = fsc_pkg::V_CONTRADICTS;
      end else if (!held_valid) begin
        held_valid = 1'b1;
        held_rate = hz;
        held_pos = idx;
        g.verdict = fsc_pkg::V_ADOPTED;
      end else begin
        g.from_held = rate_distance(hz, held_rate);
        g.verdict = (g.from_held <= AGREE_LIMIT) ? fsc_pkg::V_AGREES : fsc_pkg::V_NOT_USED;
      end
    end
    g.chosen_hz = held_valid ? held_rate : '0;
    g.chosen_idx = held_valid ? {1'b0, held_pos} : NO_PICK;
    return g;
  endfunction

  // Random rate, mostly near the measured or the adopted rate
  function automatic logic [fsc_pkg::HZ_W-1:0] draw_rate();
    logic [63:0] base;
    logic [63:0] off;
    logic [31:0] b;
    int unsigned ppm;
    b = 32'(bound_now());
    base = 64'(meas_rate);
    ppm = 0;
    case ($urandom_range(0, 11))
      0: return '0;
      1: return 40'({$urandom, $urandom});
      2: return '1;
      3: return 40'd1;
      4, 5: begin
        if (held_valid) begin
          base = 64'(held_rate);
          ppm = $urandom_range(0, 20);
        end else begin
          ppm = $urandom_range(0, b);
        end
      end
      default: begin
        ppm = $urandom_range(0, b + b / 4 + 2);
      end
    endcase
    if (base == '0) return 40'({$urandom, $urandom});
    off = base * 64'(ppm) / 64'd1000000 + 64'($urandom_range(0, 2));
    if (off < base && ($urandom_range(0, 1) == 1 || base + off > MAX_RATE)) return 40'(base - off);
    if (base + off <= MAX_RATE) return 40'(base + off);
    return 40'(base - off);
  endfunction

  function automatic void add_write(logic [fsc_pkg::CFG_IDX_W-1:0] idx,
                                    logic [fsc_pkg::HZ_W-1:0] val);
    row_t r;
    r.kind = ROW_WRITE;
    r.reg_idx = idx;
    r.reg_val = val;
    r.typed = 1'b0;
    stim_table.push_back(r);
  endfunction

  function automatic void add_source(logic [fsc_pkg::IDX_W-1:0] idx,
                                     logic [fsc_pkg::HZ_W-1:0] hz, logic first);
    row_t r;
    r.kind = ROW_SOURCE;
    r.src_idx = idx;
    r.src_hz = hz;
    r.first_flag = first;
    r.typed = 1'b0;
    stim_table.push_back(r);
  endfunction

  function automatic void add_graded(logic [fsc_pkg::IDX_W-1:0] idx,
                                     logic [fsc_pkg::HZ_W-1:0] hz, logic first,
                                     fsc_pkg::verdict_t v, logic [31:0] fm, logic [31:0] fh,
                                     logic [19:0] bd, logic [39:0] chz, logic [2:0] cidx);
    row_t r;
    r.kind = ROW_SOURCE;
    r.src_idx = idx;
    r.src_hz = hz;
    r.first_flag = first;
    r.typed = 1'b1;
    r.want = {v, fm, fh, bd, chz, cidx};
    stim_table.push_back(r);
  endfunction

  // Holds valid until the transaction is taken; the caller lowers it
  task automatic drive_source(input logic [fsc_pkg::IDX_W-1:0] idx,
                              input logic [fsc_pkg::HZ_W-1:0] hz,
                              input logic first, input bit typed, input grade_t want);
    grade_t g;
    cfg_valid <= 1'b0;
    in_tvalid <= 1'b1;
    in_tdata <= hz;
    in_tuser <= {first, idx};
    do @(posedge clk); while (!in_tready);
    g = grade_source(idx, hz, first);
    due_grades.push_back(typed ? want : g);
    sources_sent++;
  endtask

  task automatic write_reg(input logic [fsc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fsc_pkg::HZ_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      fsc_pkg::CFG_MEASURED: meas_rate = val;
      fsc_pkg::CFG_BRACKET: bracket_width = val[fsc_pkg::BRACKET_W-1:0];
      fsc_pkg::CFG_HYPERVISOR: host_slew_on = val[0];
      default: ;
    endcase
  endtask

  // Stop sending and wait for every pending grade to come back
  task automatic settle();
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    while (due_grades.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
  endtask

  // Receiver: ready follows a random 32-bit pattern, redrawn each time it wraps
  always @(posedge clk) begin
    if (stall_pos == 5'd0) begin
      case ($urandom_range(0, 3))
        0: stall_pat = '1;
        1: stall_pat = $urandom | $urandom;
        2: stall_pat = $urandom;
        default: stall_pat = $urandom & $urandom;
      endcase
    end
    out_tready <= stall_pat[stall_pos];
    stall_pos <= stall_pos + 5'd1;
  end

  // Result checker
  always @(posedge clk) begin
    grade_t got;
    grade_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.verdict = fsc_pkg::verdict_t'(out_tuser[2:0]);
      got.from_meas = out_tdata[31:0];
      got.from_held = out_tdata[63:32];
      got.bound = out_tdata[83:64];
      got.chosen_hz = out_tdata[123:84];
      got.chosen_idx = out_tdata[126:124];
      if (due_grades.size() == 0) begin
        errors++;
        $display("%0t: result transaction with no source pending, expected none, got 0x%0h",
                 $time, got);
      end else begin
        want = due_grades.pop_front();
        grades_checked++;
        check_field("verdict", 64'(want.verdict), 64'(got.verdict));
        check_field("ppm_from_measured", 64'(want.from_meas), 64'(got.from_meas));
        check_field("ppm_from_adopted", 64'(want.from_held), 64'(got.from_held));
        check_field("agree_bound", 64'(want.bound), 64'(got.bound));
        check_field("chosen_hz", 64'(want.chosen_hz), 64'(got.chosen_hz));
        check_field("chosen_index", 64'(want.chosen_idx), 64'(got.chosen_idx));
        if (got.verdict <= fsc_pkg::V_NOT_USED) verdict_seen[got.verdict]++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int unsigned burst_left;
    int unsigned gap;
    int unsigned seq_len;
    int unsigned n;
    bit in_writes;
    logic first;
    logic [fsc_pkg::IDX_W-1:0] idx;
    logic [fsc_pkg::HZ_W-1:0] meas_pick;
    logic [fsc_pkg::BRACKET_W-1:0] bracket_pick;

    // Registers at reset: nothing measured, bound 1000
    add_graded(2'd0, 40'd0, 1'b1, fsc_pkg::V_ABSENT, 0, 0, 20'd1000, 40'd0, NO_PICK);
    add_graded(2'd3, '1, 1'b0, fsc_pkg::V_UNCHECKED, 0, 0, 20'd1000, 40'd0, NO_PICK);
    // 1 GHz measured, tight bound
    add_write(fsc_pkg::CFG_MEASURED, 40'd1_000_000_000);
    add_write(fsc_pkg::CFG_BRACKET, 40'd0);
    add_write(fsc_pkg::CFG_HYPERVISOR, 40'd0);
    add_graded(2'd0, 40'd1_000_000_000, 1'b1, fsc_pkg::V_ADOPTED, 0, 0, 20'd1000,
               40'd1_000_000_000, 3'd0);
    add_graded(2'd1, 40'd1_000_000_005, 1'b0, fsc_pkg::V_AGREES, 0, 0, 20'd1000,
               40'd1_000_000_000, 3'd0);
    add_graded(2'd2, 40'd1_000_500_000, 1'b0, fsc_pkg::V_NOT_USED, 500, 500, 20'd1000,
               40'd1_000_000_000, 3'd0);
    add_graded(2'd3, 40'd2_000_000_000, 1'b0, fsc_pkg::V_CONTRADICTS, 1000000, 0, 20'd1000,
               40'd1_000_000_000, 3'd0);
    add_graded(2'd0, 40'd1, 1'b0, fsc_pkg::V_CONTRADICTS, 999999, 0, 20'd1000,
               40'd1_000_000_000, 3'd0);
    add_graded(2'd1, 40'd0, 1'b0, fsc_pkg::V_ABSENT, 0, 0, 20'd1000,
               40'd1_000_000_000, 3'd0);
    // exactly on the bound is still adopted
    add_graded(2'd2, 40'd999_000_000, 1'b1, fsc_pkg::V_ADOPTED, 1000, 0, 20'd1000,
               40'd999_000_000, 3'd2);
    add_source(2'd3, 40'd1_001_000_001, 1'b0);
    add_source(2'd1, 40'hAA_AAAA_AAAA, 1'b0);
    add_source(2'd2, 40'h55_5555_5555, 1'b1);
    // widest bracket in range plus host slew: bound 626000
    add_write(fsc_pkg::CFG_BRACKET, 40'd1_000_000);
    add_write(fsc_pkg::CFG_HYPERVISOR, 40'd1);
    add_graded(2'd1, 40'd1_500_000_000, 1'b1, fsc_pkg::V_ADOPTED, 500000, 0, 20'd626000,
               40'd1_500_000_000, 3'd1);
    add_graded(2'd0, 40'd1_626_000_000, 1'b0, fsc_pkg::V_NOT_USED, 626000, 84000, 20'd626000,
               40'd1_500_000_000, 3'd1);
    add_graded(2'd2, 40'd1_626_001_000, 1'b0, fsc_pkg::V_CONTRADICTS, 626001, 0, 20'd626000,
               40'd1_500_000_000, 3'd1);
    // 1 Hz measured, bracket above its range; distances saturate
    add_write(fsc_pkg::CFG_MEASURED, 40'd1);
    add_write(fsc_pkg::CFG_BRACKET, 40'hF_FFFF);
    add_graded(2'd0, '1, 1'b1, fsc_pkg::V_CONTRADICTS, 32'hFFFF_FFFF, 0, 20'd650287,
               40'd0, NO_PICK);
    add_graded(2'd3, 40'd1, 1'b0, fsc_pkg::V_ADOPTED, 0, 0, 20'd650287, 40'd1, 3'd3);
    add_graded(2'd0, 40'd1, 1'b0, fsc_pkg::V_AGREES, 0, 0, 20'd650287, 40'd1, 3'd3);
    // largest measurement; a write to the spare index changes nothing
    add_write(fsc_pkg::CFG_MEASURED, '1);
    add_write(fsc_pkg::CFG_BRACKET, 40'd0);
    add_write(fsc_pkg::CFG_HYPERVISOR, 40'd0);
    add_write(CFG_SPARE, '1);
    add_graded(2'd3, '1, 1'b1, fsc_pkg::V_ADOPTED, 0, 0, 20'd1000, '1, 3'd3);
    add_graded(2'd1, 40'hFF_FFFF_FFFE, 1'b0, fsc_pkg::V_AGREES, 0, 0, 20'd1000, '1, 3'd3);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    in_writes = 1'b0;
    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_WRITE) begin
        if (!in_writes) begin
          settle();
          settings_used++;
        end
        write_reg(stim_table[i].reg_idx, stim_table[i].reg_val);
        in_writes = 1'b1;
      end else begin
        drive_source(stim_table[i].src_idx, stim_table[i].src_hz, stim_table[i].first_flag,
                     stim_table[i].typed, stim_table[i].want);
        in_writes = 1'b0;
      end
    end
    directed_sent = sources_sent;

    // Random phases, each under new register settings
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      case ($urandom_range(0, 9))
        0: meas_pick = '0;
        1: meas_pick = 40'($urandom_range(1, 1000));
        2: meas_pick = '1;
        3: meas_pick = 40'({$urandom, $urandom});
        default: meas_pick = 40'($urandom_range(1000000, 32'hFFFF_FFFF));
      endcase
      case ($urandom_range(0, 5))
        0: bracket_pick = '0;
        1: bracket_pick = 20'd1000000;
        2: bracket_pick = '1;
        3: bracket_pick = 20'($urandom);
        default: bracket_pick = 20'($urandom_range(0, 200000));
      endcase
      write_reg(fsc_pkg::CFG_MEASURED, meas_pick);
      write_reg(fsc_pkg::CFG_BRACKET, 40'(bracket_pick));
      write_reg(fsc_pkg::CFG_HYPERVISOR, 40'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, 40'({$urandom, $urandom}));
      settings_used++;

      burst_left = $urandom_range(1, 12);
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        // one choice: sources mostly in precedence order, the first one usually opens it
        seq_len = $urandom_range(1, 5);
        for (int k = 0; k < seq_len; k++) begin
          first = (k == 0);
          idx = 2'(k);
          if ($urandom_range(0, 7) == 0) first = 1'($urandom);
          if ($urandom_range(0, 5) == 0) idx = 2'($urandom);
          drive_source(idx, draw_rate(), first, 1'b0, '0);
          n++;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if ($urandom_range(0, 15) == 0) begin
              settle();
            end else if (gap > 0) begin
              in_tvalid <= 1'b0;
              repeat (gap) @(posedge clk);
            end
          end
        end
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Graded %0d sources (%0d from the directed table) under %0d register settings;",
             sources_sent, directed_sent, settings_used);
    $display("%0d results checked. Verdicts: absent %0d, unchecked %0d, contradicts %0d,",
             grades_checked, verdict_seen[0], verdict_seen[1], verdict_seen[2]);
    $display("adopted %0d, agrees %0d, not used %0d",
             verdict_seen[3], verdict_seen[4], verdict_seen[5]);
    if (errors == 0 && due_grades.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
